[hdl/rpd_pkg.sv]
// Shared codes and result type for the readout packet deframer.
`default_nettype none

package rpd_pkg;

    localparam logic [15:0] START_WORD = 16'hA1FA;
    localparam logic [15:0] END_WORD   = 16'h0E6A;

    localparam logic [2:0] KIND_ADDRESS   = 3'd0;
    localparam logic [2:0] KIND_COARSE    = 3'd1;
    localparam logic [2:0] KIND_TRIGGER   = 3'd2;
    localparam logic [2:0] KIND_BYTE_PAIR = 3'd3;
    localparam logic [2:0] KIND_SAMPLE    = 3'd4;
    localparam logic [2:0] KIND_END_OK    = 3'd5;
    localparam logic [2:0] KIND_ERROR     = 3'd6;

    localparam logic ERR_BAD_START = 1'b0;
    localparam logic ERR_BAD_END   = 1'b1;

    localparam logic [11:0] SAMPLE_MASK = 12'hFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  word_position;
        logic [31:0] wide_value;
        logic [7:0]  high_byte;
        logic [7:0]  low_byte;
        logic [2:0]  bus_addr;
        logic [3:0]  cfg_addr;
        logic        bank;
        logic [7:0]  sample_index;
        logic [3:0]  channel;
        logic [11:0] sample_value;
        logic        error_code;
    } t_result;

endpackage

`default_nettype wire

[hdl/readout_packet_deframer_core.sv]
// Readout packet deframer: splits a 16-bit word stream into header fields and samples.
//
// Input channel: i_in_valid / o_in_stall carry one stream word per transaction on i_word.
// Output channel: o_out_valid / i_out_stall carry one decoded result per transaction.
// Each word yields zero or one result: the start word and the first coarse-time
// word yield none, every other word yields one (header field, sample, end or error).
// A word enters the input register when it is accepted; its result is
// written to the result register and leaves from there.
// Throughput is one word per cycle while o_in_stall is low; the decode is a single pass
// of field extraction and counter update between the input register and the result register.
// When the receiver stalls, the result register holds, and the input register
// still takes words that give no result; a word with a result waits in the input
// register and stalls the sender only while the result register is full and the
// receiver stalls.
// Reset (synchronous, i_rst_n low) empties both registers and returns the parser
// to idle, waiting for the start word. Sample rows are counted against CHANNELS,
// and ring indices wrap at RING_DEPTH.
`default_nettype none

module readout_packet_deframer_core #(
    parameter int CHANNELS   = 16,
    parameter int RING_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_kind,
    output logic [2:0]       o_word_position,
    output logic [31:0]      o_wide_value,
    output logic [7:0]       o_high_byte,
    output logic [7:0]       o_low_byte,
    output logic [2:0]       o_bus_addr,
    output logic [3:0]       o_cfg_addr,
    output logic             o_bank,
    output logic [7:0]       o_sample_index,
    output logic [3:0]       o_channel,
    output logic [11:0]      o_sample_value,
    output logic             o_error_code
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_HDR4,
        ST_HDR5,
        ST_HDR6,
        ST_HDR7,
        ST_SAMPLES,
        ST_TRAILER
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_coarse_high, n_coarse_high;
    logic [8:0]        r_rows_left, n_rows_left;
    logic [3:0]        r_chan, n_chan;
    logic [7:0]        r_ring, n_ring;

    logic              r_in_valid;
    logic [15:0]       r_in_word;
    logic              r_out_valid;
    rpd_pkg::t_result  r_out;

    rpd_pkg::t_result  res;
    logic              res_valid;
    logic              out_free;
    logic              proc;

    logic [7:0]        ring_start_tab [256];
    logic [4:0]        chan_inc;
    logic [8:0]        ring_inc;

    // ring start lookup, folded at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_ring_tab
        assign ring_start_tab[g] = 8'(g % RING_DEPTH);
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!res_valid || out_free);
    assign o_in_stall = r_in_valid && !proc;

    assign chan_inc = {1'b0, r_chan} + 5'd1;
    assign ring_inc = {1'b0, r_ring} + 9'd1;

    always_comb begin
        res           = '0;
        res_valid     = 1'b1;
        n_phase       = r_phase;
        n_coarse_high = r_coarse_high;
        n_rows_left   = r_rows_left;
        n_chan        = r_chan;
        n_ring        = r_ring;
        unique case (r_phase)
            ST_IDLE: begin
                if (r_in_word == rpd_pkg::START_WORD) begin
                    res_valid = 1'b0;
                    n_phase   = ST_HDR1;
                end else begin
                    res.kind       = rpd_pkg::KIND_ERROR;
                    res.error_code = rpd_pkg::ERR_BAD_START;
                end
            end
            ST_HDR1: begin
                res.kind          = rpd_pkg::KIND_ADDRESS;
                res.word_position = 3'd1;
                res.low_byte      = r_in_word[7:0];
                res.bus_addr      = r_in_word[15:13];
                res.cfg_addr      = r_in_word[12:9];
                res.bank          = r_in_word[8];
                n_phase           = ST_HDR2;
            end
            ST_HDR2: begin
                res_valid     = 1'b0;
                n_coarse_high = r_in_word;
                n_phase       = ST_HDR3;
            end
            ST_HDR3: begin
                res.kind          = rpd_pkg::KIND_COARSE;
                res.word_position = 3'd3;
                res.wide_value    = {r_coarse_high, r_in_word};
                n_phase           = ST_HDR4;
            end
            ST_HDR4: begin
                res.kind          = rpd_pkg::KIND_TRIGGER;
                res.word_position = 3'd4;
                res.wide_value    = {16'd0, r_in_word};
                n_phase           = ST_HDR5;
            end
            ST_HDR5: begin
                res.kind          = rpd_pkg::KIND_BYTE_PAIR;
                res.word_position = 3'd5;
                res.high_byte     = r_in_word[15:8];
                res.low_byte      = r_in_word[7:0];
                n_phase           = ST_HDR6;
            end
            ST_HDR6: begin
                res.kind          = rpd_pkg::KIND_BYTE_PAIR;
                res.word_position = 3'd6;
                res.high_byte     = r_in_word[15:8];
                res.low_byte      = r_in_word[7:0];
                n_rows_left       = {1'b0, r_in_word[15:8]} + 9'd1;
                n_ring            = ring_start_tab[r_in_word[7:0]];
                n_chan            = '0;
                n_phase           = ST_HDR7;
            end
            ST_HDR7: begin
                res.kind          = rpd_pkg::KIND_BYTE_PAIR;
                res.word_position = 3'd7;
                res.high_byte     = r_in_word[15:8];
                res.low_byte      = r_in_word[7:0];
                n_phase           = ST_SAMPLES;
            end
            ST_SAMPLES: begin
                res.kind         = rpd_pkg::KIND_SAMPLE;
                res.sample_index = r_ring;
                res.channel      = r_chan;
                res.sample_value = r_in_word[11:0] & rpd_pkg::SAMPLE_MASK;
                if (chan_inc >= 5'(CHANNELS)) begin
                    n_chan = '0;
                    n_ring = (ring_inc >= 9'(RING_DEPTH)) ? 8'd0 : ring_inc[7:0];
                    n_rows_left = (r_rows_left == 9'd0) ? 9'd0 : r_rows_left - 9'd1;
                    if (n_rows_left == 9'd0) begin
                        n_phase = ST_TRAILER;
                    end
                end else begin
                    n_chan = chan_inc[3:0];
                end
            end
            ST_TRAILER: begin
                if (r_in_word == rpd_pkg::END_WORD) begin
                    res.kind = rpd_pkg::KIND_END_OK;
                end else begin
                    res.kind       = rpd_pkg::KIND_ERROR;
                    res.error_code = rpd_pkg::ERR_BAD_END;
                end
                n_phase = ST_IDLE;
            end
            default: begin
                res.kind = rpd_pkg::KIND_ERROR;
                n_phase  = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ST_IDLE;
            r_coarse_high <= '0;
            r_rows_left   <= '0;
            r_chan        <= '0;
            r_ring        <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_phase       <= n_phase;
                r_coarse_high <= n_coarse_high;
                r_rows_left   <= n_rows_left;
                r_chan        <= n_chan;
                r_ring        <= n_ring;
            end
            if (out_free) begin
                r_out_valid <= proc && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_word;
        end
        if (out_free && proc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_word_position = r_out.word_position;
    assign o_wide_value    = r_out.wide_value;
    assign o_high_byte     = r_out.high_byte;
    assign o_low_byte      = r_out.low_byte;
    assign o_bus_addr      = r_out.bus_addr;
    assign o_cfg_addr      = r_out.cfg_addr;
    assign o_bank          = r_out.bank;
    assign o_sample_index  = r_out.sample_index;
    assign o_channel       = r_out.channel;
    assign o_sample_value  = r_out.sample_value;
    assign o_error_code    = r_out.error_code;

    a_stall_only_when_holding: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && res_valid && r_out_valid && i_out_stall)
    ) else $error("input stalled without a blocked result");

    a_chan_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_chan} < 5'(CHANNELS)
    ) else $error("channel counter beyond channel count");

    a_ring_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ring} < 9'(RING_DEPTH)
    ) else $error("ring position beyond ring depth");

    a_sample_fields_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == rpd_pkg::KIND_SAMPLE)
            |-> (r_out.word_position == 3'd0 && r_out.wide_value == 32'd0)
    ) else $error("sample result carries header fields");

    a_trailer_returns_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_phase == ST_TRAILER) |=> (r_phase == ST_IDLE)
    ) else $error("parser did not return to idle after trailer");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the readout packet deframer: directed words, then random packets.
module tb;

    localparam int CHANNELS    = 16;
    localparam int RING_DEPTH  = 256;
    localparam int ITEM_TARGET = 1550;
    localparam int DIR_ROWS    = 27;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [2:0] POS_ADDRESS = 3'd1;
    localparam logic [2:0] POS_COARSE  = 3'd3;
    localparam logic [2:0] POS_TRIGGER = 3'd4;
    localparam logic [2:0] POS_PAIR5   = 3'd5;
    localparam logic [2:0] POS_PAIR6   = 3'd6;
    localparam logic [2:0] POS_PAIR7   = 3'd7;

    localparam rpd_pkg::t_result NO_RESULT = '0;

    typedef enum logic [3:0] {
        P_IDLE, P_ADDR, P_COARSE_HI, P_COARSE_LO, P_TRIGGER,
        P_PAIR5, P_PAIR6, P_PAIR7, P_SAMPLES, P_TRAILER
    } t_phase;

    typedef struct packed {
        logic [15:0]      word;
        logic             given;
        rpd_pkg::t_result want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [15:0] i_word      = 16'h0000;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_kind;
    logic [2:0]  o_word_position;
    logic [31:0] o_wide_value;
    logic [7:0]  o_high_byte;
    logic [7:0]  o_low_byte;
    logic [2:0]  o_bus_addr;
    logic [3:0]  o_cfg_addr;
    logic        o_bank;
    logic [7:0]  o_sample_index;
    logic [3:0]  o_channel;
    logic [11:0] o_sample_value;
    logic        o_error_code;

    t_phase      phase_q     = P_IDLE;
    logic [15:0] coarse_hi_q = '0;
    logic [8:0]  rows_left_q = '0;
    logic [3:0]  chan_q      = '0;
    logic [7:0]  ring_q      = '0;

    rpd_pkg::t_result pending_results[$];
    t_dir_row    dir_rows[DIR_ROWS];
    int          words_sent = 0;
    int          mismatches = 0;
    bit          calm       = 1'b0;
    bit          want_hold  = 1'b0;

    readout_packet_deframer_core #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_word          (i_word),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_word_position (o_word_position),
        .o_wide_value    (o_wide_value),
        .o_high_byte     (o_high_byte),
        .o_low_byte      (o_low_byte),
        .o_bus_addr      (o_bus_addr),
        .o_cfg_addr      (o_cfg_addr),
        .o_bank          (o_bank),
        .o_sample_index  (o_sample_index),
        .o_channel       (o_channel),
        .o_sample_value  (o_sample_value),
        .o_error_code    (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic rpd_pkg::t_result make_result(input logic [2:0] kind,
                                                     input logic [2:0] pos,
                                                     input logic [31:0] wide,
                                                     input logic [7:0] hi,
                                                     input logic [7:0] lo,
                                                     input logic [2:0] bus,
                                                     input logic [3:0] cfg,
                                                     input logic bank,
                                                     input logic code);
        rpd_pkg::t_result r;
        r = '0;
        r.kind          = kind;
        r.word_position = pos;
        r.wide_value    = wide;
        r.high_byte     = hi;
        r.low_byte      = lo;
        r.bus_addr      = bus;
        r.cfg_addr      = cfg;
        r.bank          = bank;
        r.error_code    = code;
        return r;
    endfunction

    task automatic decode_word(input logic [15:0] w, output bit has,
                               output rpd_pkg::t_result r);
        r   = '0;
        has = 1'b1;
        case (phase_q)
            P_IDLE: begin
                if (w == rpd_pkg::START_WORD) begin
                    phase_q = P_ADDR;
                    has     = 1'b0;
                end else begin
                    r.kind       = rpd_pkg::KIND_ERROR;
                    r.error_code = rpd_pkg::ERR_BAD_START;
                end
            end
            P_ADDR: begin
                r.kind          = rpd_pkg::KIND_ADDRESS;
                r.word_position = POS_ADDRESS;
                r.low_byte      = w[7:0];
                r.bus_addr      = w[15:13];
                r.cfg_addr      = w[12:9];
                r.bank          = w[8];
                phase_q         = P_COARSE_HI;
            end
            P_COARSE_HI: begin
                coarse_hi_q = w;
                has         = 1'b0;
                phase_q     = P_COARSE_LO;
            end
            P_COARSE_LO: begin
                r.kind          = rpd_pkg::KIND_COARSE;
                r.word_position = POS_COARSE;
                r.wide_value    = {coarse_hi_q, w};
                phase_q         = P_TRIGGER;
            end
            P_TRIGGER: begin
                r.kind          = rpd_pkg::KIND_TRIGGER;
                r.word_position = POS_TRIGGER;
                r.wide_value    = {16'h0000, w};
                phase_q         = P_PAIR5;
            end
            P_PAIR5, P_PAIR6, P_PAIR7: begin
                r.kind      = rpd_pkg::KIND_BYTE_PAIR;
                r.high_byte = w[15:8];
                r.low_byte  = w[7:0];
                case (phase_q)
                    P_PAIR5: begin
                        r.word_position = POS_PAIR5;
                        phase_q         = P_PAIR6;
                    end
                    P_PAIR6: begin
                        r.word_position = POS_PAIR6;
                        rows_left_q     = {1'b0, w[15:8]} + 9'd1;
                        ring_q          = 8'(int'(w[7:0]) % RING_DEPTH);
                        chan_q          = '0;
                        phase_q         = P_PAIR7;
                    end
                    default: begin
                        r.word_position = POS_PAIR7;
                        phase_q         = P_SAMPLES;
                    end
                endcase
            end
            P_SAMPLES: begin
                r.kind         = rpd_pkg::KIND_SAMPLE;
                r.sample_index = ring_q;
                r.channel      = chan_q;
                r.sample_value = w[11:0] & rpd_pkg::SAMPLE_MASK;
                if (int'(chan_q) + 1 >= CHANNELS) begin
                    chan_q = '0;
                    ring_q = (int'(ring_q) + 1 >= RING_DEPTH) ? 8'd0 : ring_q + 8'd1;
                    if (rows_left_q != 9'd0) rows_left_q = rows_left_q - 9'd1;
                    if (rows_left_q == 9'd0) phase_q = P_TRAILER;
                end else begin
                    chan_q = chan_q + 4'd1;
                end
            end
            P_TRAILER: begin
                if (w == rpd_pkg::END_WORD) begin
                    r.kind = rpd_pkg::KIND_END_OK;
                end else begin
                    r.kind       = rpd_pkg::KIND_ERROR;
                    r.error_code = rpd_pkg::ERR_BAD_END;
                end
                phase_q = P_IDLE;
            end
            default: begin
                r.kind  = rpd_pkg::KIND_ERROR;
                phase_q = P_IDLE;
            end
        endcase
    endtask

    // Enter and leave at a falling edge.
    task automatic send_word(input logic [15:0] w, input bit given,
                             input rpd_pkg::t_result want);
        bit               has;
        rpd_pkg::t_result r;
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_word     <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_word(w, has, r);
        if (given) pending_results.push_back(want);
        else if (has) pending_results.push_back(r);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin : out_stall_drive
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (want_hold) begin
                want_hold = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 36);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        rpd_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction: kind 0x%0h", o_kind);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("word_position", 32'(want.word_position),
                            32'(o_word_position));
                check_field("wide_value", want.wide_value, o_wide_value);
                check_field("high_byte", 32'(want.high_byte), 32'(o_high_byte));
                check_field("low_byte", 32'(want.low_byte), 32'(o_low_byte));
                check_field("bus_addr", 32'(want.bus_addr), 32'(o_bus_addr));
                check_field("cfg_addr", 32'(want.cfg_addr), 32'(o_cfg_addr));
                check_field("bank", 32'(want.bank), 32'(o_bank));
                check_field("sample_index", 32'(want.sample_index), 32'(o_sample_index));
                check_field("channel", 32'(want.channel), 32'(o_channel));
                check_field("sample_value", 32'(want.sample_value), 32'(o_sample_value));
                check_field("error_code", 32'(want.error_code), 32'(o_error_code));
            end
        end
    end

    initial begin : stimulus
        bit          hold_asked;
        int          shape;
        int          rows;
        int          k;
        logic [7:0]  count;
        logic [7:0]  ring_start;
        logic [15:0] w;

        hold_asked = 1'b0;

        dir_rows[0]  = '{16'h0000, 1'b1,
                         make_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0,
                                     rpd_pkg::ERR_BAD_START)};
        dir_rows[1]  = '{16'hFFFF, 1'b1,
                         make_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0,
                                     rpd_pkg::ERR_BAD_START)};
        dir_rows[2]  = '{rpd_pkg::START_WORD, 1'b0, NO_RESULT};
        dir_rows[3]  = '{16'hFFFF, 1'b1,
                         make_result(rpd_pkg::KIND_ADDRESS, POS_ADDRESS, 0, 0, 8'hFF, 3'h7,
                                     4'hF, 1'b1, 0)};
        dir_rows[4]  = '{16'hFFFF, 1'b0, NO_RESULT};
        dir_rows[5]  = '{16'hFFFF, 1'b1,
                         make_result(rpd_pkg::KIND_COARSE, POS_COARSE, 32'hFFFF_FFFF, 0, 0,
                                     0, 0, 0, 0)};
        dir_rows[6]  = '{16'h0000, 1'b1,
                         make_result(rpd_pkg::KIND_TRIGGER, POS_TRIGGER, 0, 0, 0, 0, 0, 0,
                                     0)};
        dir_rows[7]  = '{16'hFFFF, 1'b1,
                         make_result(rpd_pkg::KIND_BYTE_PAIR, POS_PAIR5, 0, 8'hFF, 8'hFF, 0,
                                     0, 0, 0)};
        dir_rows[8]  = '{16'h00FF, 1'b1,
                         make_result(rpd_pkg::KIND_BYTE_PAIR, POS_PAIR6, 0, 8'h00, 8'hFF, 0,
                                     0, 0, 0)};
        dir_rows[9]  = '{16'h0000, 1'b1,
                         make_result(rpd_pkg::KIND_BYTE_PAIR, POS_PAIR7, 0, 0, 0, 0, 0, 0,
                                     0)};
        dir_rows[10] = '{16'hFFFF, 1'b0, NO_RESULT};
        dir_rows[11] = '{16'h0000, 1'b0, NO_RESULT};
        dir_rows[12] = '{16'hF000, 1'b0, NO_RESULT};
        dir_rows[13] = '{16'h0FFF, 1'b0, NO_RESULT};
        dir_rows[14] = '{16'h8001, 1'b0, NO_RESULT};
        dir_rows[15] = '{16'h7FFE, 1'b0, NO_RESULT};
        dir_rows[16] = '{rpd_pkg::START_WORD, 1'b0, NO_RESULT};
        dir_rows[17] = '{rpd_pkg::END_WORD, 1'b0, NO_RESULT};
        dir_rows[18] = '{16'h1234, 1'b0, NO_RESULT};
        dir_rows[19] = '{16'hABCD, 1'b0, NO_RESULT};
        dir_rows[20] = '{16'h5555, 1'b0, NO_RESULT};
        dir_rows[21] = '{16'hAAAA, 1'b0, NO_RESULT};
        dir_rows[22] = '{16'h0001, 1'b0, NO_RESULT};
        dir_rows[23] = '{16'h8000, 1'b0, NO_RESULT};
        dir_rows[24] = '{16'hC3C3, 1'b0, NO_RESULT};
        dir_rows[25] = '{16'h3C3C, 1'b0, NO_RESULT};
        dir_rows[26] = '{rpd_pkg::END_WORD, 1'b1,
                         make_result(rpd_pkg::KIND_END_OK, 0, 0, 0, 0, 0, 0, 0, 0)};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_word(dir_rows[k].word, dir_rows[k].given, dir_rows[k].want);

        while (words_sent < ITEM_TARGET) begin
            calm = (words_sent >= 400 && words_sent < 700);
            if (words_sent >= 900 && !hold_asked) begin
                hold_asked = 1'b1;
                want_hold  = 1'b1;
            end
            shape = $urandom_range(99);
            if (shape < 10) begin
                repeat ($urandom_range(1, 4)) begin
                    w = ($urandom_range(3) == 0) ? rpd_pkg::END_WORD : 16'($urandom);
                    send_word(w, 1'b0, NO_RESULT);
                end
            end else begin
                send_word(rpd_pkg::START_WORD, 1'b0, NO_RESULT);
                repeat (5) send_word(16'($urandom), 1'b0, NO_RESULT);
                k = $urandom_range(99);
                if (k < 60) count = 8'd0;
                else if (k < 90) count = 8'($urandom_range(1, 3));
                else count = 8'($urandom_range(4, 15));
                ring_start = ($urandom_range(1) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(250, 255));
                send_word({count, ring_start}, 1'b0, NO_RESULT);
                send_word(16'($urandom), 1'b0, NO_RESULT);
                rows = int'(count) + 1;
                repeat (rows * CHANNELS) begin
                    k = $urandom_range(9);
                    w = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
                    send_word(w, 1'b0, NO_RESULT);
                end
                if (shape < 22) begin
                    w = ($urandom_range(1) == 0) ? rpd_pkg::START_WORD : 16'($urandom);
                    if (w == rpd_pkg::END_WORD) w = w ^ 16'h0001;
                end else begin
                    w = rpd_pkg::END_WORD;
                end
                send_word(w, 1'b0, NO_RESULT);
            end
        end

        i_in_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_results.size() != 0; k++) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
